// ----- rtl/core/hse_pkg.sv -----
// Shared types for the 2x2 Hessian eigen decomposition pipeline.
package hse_pkg;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

// ----- rtl/core/hse_sqrt_cell.sv -----
// One bit step of a pipelined restoring integer square root, per lane.
module hse_sqrt_cell #(
  parameter int N = 17,
  parameter int LANES = 1,
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hse_pkg::ctl_t                 ctl_in,
  input  logic [LANES-1:0][2*N-1:0]     x_in,
  input  logic [LANES-1:0][N:0]         rem_in,
  input  logic [LANES-1:0][N-1:0]       root_in,
  input  logic [PW-1:0]                 pl_in,
  output hse_pkg::ctl_t                 ctl_out,
  output logic [LANES-1:0][2*N-1:0]     x_out,
  output logic [LANES-1:0][N:0]         rem_out,
  output logic [LANES-1:0][N-1:0]       root_out,
  output logic [PW-1:0]                 pl_out
);

  logic [LANES-1:0][2*N-1:0] x_next;
  logic [LANES-1:0][N:0]     rem_next;
  logic [LANES-1:0][N-1:0]   root_next;

  always_comb begin
    logic [N+2:0] rem_sh;
    logic [N+2:0] trial;
    logic [N+2:0] diff;
    logic         ge;
    for (int l = 0; l < LANES; l++) begin
      rem_sh = {rem_in[l], x_in[l][2*N-1 -: 2]};
      trial  = {1'b0, root_in[l], 2'b01};
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
      rem_next[l]  = ge ? diff[N:0] : rem_sh[N:0];
      root_next[l] = {root_in[l][N-2:0], ge};
      x_next[l]    = {x_in[l][2*N-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    x_out    <= x_next;
    rem_out  <= rem_next;
    root_out <= root_next;
    pl_out   <= pl_in;
  end

endmodule

// ----- rtl/core/hse_div_cell.sv -----
// One quotient bit step of a pipelined restoring divider, per lane.
module hse_div_cell #(
  parameter int SW = 37,
  parameter int QW = 29,
  parameter int LANES = 2,
  parameter int PW = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hse_pkg::ctl_t              ctl_in,
  input  logic [SW-1:0]              dvs_in,
  input  logic [LANES-1:0][SW-1:0]   rem_in,
  input  logic [LANES-1:0][QW-1:0]   quo_in,
  input  logic [PW-1:0]              pl_in,
  output hse_pkg::ctl_t              ctl_out,
  output logic [SW-1:0]              dvs_out,
  output logic [LANES-1:0][SW-1:0]   rem_out,
  output logic [LANES-1:0][QW-1:0]   quo_out,
  output logic [PW-1:0]              pl_out
);

  logic [LANES-1:0][SW-1:0] rem_next;
  logic [LANES-1:0][QW-1:0] quo_next;

  always_comb begin
    logic [SW:0] sh;
    logic [SW:0] diff;
    logic        ge;
    for (int l = 0; l < LANES; l++) begin
      sh   = {rem_in[l], 1'b0};
      diff = sh - {1'b0, dvs_in};
      ge   = (sh >= {1'b0, dvs_in});
      rem_next[l] = ge ? diff[SW-1:0] : sh[SW-1:0];
      quo_next[l] = {quo_in[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    dvs_out <= dvs_in;
    rem_out <= rem_next;
    quo_out <= quo_next;
    pl_out  <= pl_in;
  end

endmodule

// ----- rtl/core/hessian_eigen_2x2.sv -----
// Top level: per-pixel eigen decomposition of a symmetric 2x2 Hessian.
//
// Channel  | Handshake       | Fields
// input    | start / busy    | hess_xx, hess_xy, hess_yy, last_pixel
// result   | done (strobe)   | small_eig_x2, large_eig_x2, small_vec_x/y, large_vec_x/y, last_out
//
// One item enters every cycle; busy is always low.
// Most of the pipeline is made up of the chains of
// one-bit cells: the discriminant root, the normalizing divider and the vector roots.
// Reset clears the valid flags of every stage; data registers are not reset.
// Results cannot be held off, so nothing in the chain ever stalls.
module hessian_eigen_2x2 #(
  parameter int IN_WIDTH = 16,
  parameter int VEC_FRAC = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] hess_xx,
  input  logic signed [IN_WIDTH-1:0] hess_xy,
  input  logic signed [IN_WIDTH-1:0] hess_yy,
  input  logic                       last_pixel,
  output logic                       done,
  output logic signed [IN_WIDTH+2:0] small_eig_x2,
  output logic signed [IN_WIDTH+2:0] large_eig_x2,
  output logic signed [VEC_FRAC+1:0] small_vec_x,
  output logic signed [VEC_FRAC+1:0] small_vec_y,
  output logic signed [VEC_FRAC+1:0] large_vec_x,
  output logic signed [VEC_FRAC+1:0] large_vec_y,
  output logic                       last_out
);

  localparam int W   = IN_WIDTH;
  localparam int F   = VEC_FRAC;
  localparam int RN  = W + 1;
  localparam int DW  = 2 * W + 2;
  localparam int EW  = W + 3;
  localparam int VYW = W + 2;
  localparam int SW  = 2 * W + 5;
  localparam int QW  = 2 * F + 1;
  localparam int VN  = F + 1;
  localparam int OW  = F + 2;
  localparam int PW1 = 3 * (W + 1);
  localparam int PW2 = 3 + 2 * EW;

  assign busy = 1'b0;

  // Front end: differences, squares, discriminant.
  hse_pkg::ctl_t       ctl1, ctl2, ctl3;
  logic signed [W:0]   d1, vx1, sum1, d2, vx2, sum2, d3, vx3, sum3;
  logic [DW-1:0]       dsq2, tsq2, disc3;
  logic [W:0]          dmag, tmag;

  assign dmag = d1[W] ? (W+1)'(0) - d1 : d1;
  assign tmag = vx1[W] ? (W+1)'(0) - vx1 : vx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else begin
      ctl1 <= '{valid: start, last: last_pixel};
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
    d1    <= {hess_xx[W-1], hess_xx} - {hess_yy[W-1], hess_yy};
    vx1   <= {hess_xy, 1'b0};
    sum1  <= {hess_xx[W-1], hess_xx} + {hess_yy[W-1], hess_yy};
    dsq2  <= DW'(dmag) * DW'(dmag);
    tsq2  <= DW'(tmag) * DW'(tmag);
    d2    <= d1;
    vx2   <= vx1;
    sum2  <= sum1;
    disc3 <= dsq2 + tsq2;
    d3    <= d2;
    vx3   <= vx2;
    sum3  <= sum2;
  end

  // Discriminant root chain.
  hse_pkg::ctl_t        r_ctl  [0:RN];
  logic [0:0][DW-1:0]   r_x    [0:RN];
  logic [0:0][RN:0]     r_rem  [0:RN];
  logic [0:0][RN-1:0]   r_root [0:RN];
  logic [PW1-1:0]       r_pl   [0:RN];

  assign r_ctl[0]  = ctl3;
  assign r_x[0]    = disc3;
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_pl[0]   = {d3, vx3, sum3};

  for (genvar i = 0; i < RN; i++) begin : g_root
    hse_sqrt_cell #(.N(RN), .LANES(1), .PW(PW1)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(r_ctl[i]), .x_in(r_x[i]), .rem_in(r_rem[i]), .root_in(r_root[i]),
      .pl_in(r_pl[i]),
      .ctl_out(r_ctl[i+1]), .x_out(r_x[i+1]), .rem_out(r_rem[i+1]),
      .root_out(r_root[i+1]), .pl_out(r_pl[i+1])
    );
  end

  // Eigenvalues, ordering, vector and its squared length.
  logic [RN-1:0]        root;
  logic signed [W:0]    d4i, vx4i, sum4i;
  logic [EW-1:0]        vy_w, lam1_w, lam2_w, a1, a2;

  assign root = r_root[RN][0];
  assign {d4i, vx4i, sum4i} = r_pl[RN];
  assign vy_w   = {2'b00, root} - {{2{d4i[W]}}, d4i};
  assign lam1_w = {{2{sum4i[W]}}, sum4i} - {2'b00, root};
  assign lam2_w = {{2{sum4i[W]}}, sum4i} + {2'b00, root};
  assign a1 = lam1_w[EW-1] ? EW'(0) - lam1_w : lam1_w;
  assign a2 = lam2_w[EW-1] ? EW'(0) - lam2_w : lam2_w;

  hse_pkg::ctl_t      ctl4, ctl5, ctl6, ctl7;
  logic signed [W:0]  vx4;
  logic [VYW-1:0]     vy4;
  logic [EW-1:0]      lam1_4, lam2_4, lam1_5, lam2_5, lam1_6, lam2_6;
  logic               swap4, swap5, swap6, neg5, neg6;
  logic [W:0]         vxmag;
  logic [DW-1:0]      vxsq5;
  logic [2*VYW-1:0]   vysq5;
  logic [SW-1:0]      s6, nx6, ny6, s_w, nxr, nyr;
  logic               gex, gey;
  logic [SW-1:0]      s7;
  logic [1:0][SW-1:0] rem7;
  logic [1:0][QW-1:0] quo7;
  logic [PW2-1:0]     pl7;

  assign vxmag = vx4[W] ? (W+1)'(0) - vx4 : vx4;
  assign gex = (nx6 >= s6);
  assign gey = (ny6 >= s6);
  assign nxr = gex ? nx6 - s6 : nx6;
  assign nyr = gey ? ny6 - s6 : ny6;
  assign s_w = SW'(vxsq5) + SW'(vysq5);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
      ctl5 <= '0;
      ctl6 <= '0;
      ctl7 <= '0;
    end else begin
      ctl4 <= r_ctl[RN];
      ctl5 <= ctl4;
      ctl6 <= ctl5;
      ctl7 <= ctl6;
    end
    vx4    <= vx4i;
    vy4    <= vy_w[VYW-1:0];
    lam1_4 <= lam1_w;
    lam2_4 <= lam2_w;
    swap4  <= (a1 > a2);
    vxsq5  <= DW'(vxmag) * DW'(vxmag);
    vysq5  <= (2*VYW)'(vy4) * (2*VYW)'(vy4);
    neg5   <= vx4[W];
    lam1_5 <= lam1_4;
    lam2_5 <= lam2_4;
    swap5  <= swap4;
    s6     <= s_w;
    nx6    <= SW'(vxsq5);
    ny6    <= SW'(vysq5);
    neg6   <= neg5;
    lam1_6 <= lam1_5;
    lam2_6 <= lam2_5;
    swap6  <= swap5;
    s7     <= s6;
    rem7   <= {nyr, nxr};
    quo7   <= {QW'(gey), QW'(gex)};
    pl7    <= {swap6, neg6, (s6 == '0), lam1_6, lam2_6};
  end

  // Normalizing divider chain: quotient of squared component over squared length.
  localparam int DN = 2 * F;
  hse_pkg::ctl_t       q_ctl [0:DN];
  logic [SW-1:0]       q_dvs [0:DN];
  logic [1:0][SW-1:0]  q_rem [0:DN];
  logic [1:0][QW-1:0]  q_quo [0:DN];
  logic [PW2-1:0]      q_pl  [0:DN];

  assign q_ctl[0] = ctl7;
  assign q_dvs[0] = s7;
  assign q_rem[0] = rem7;
  assign q_quo[0] = quo7;
  assign q_pl[0]  = pl7;

  for (genvar i = 0; i < DN; i++) begin : g_div
    hse_div_cell #(.SW(SW), .QW(QW), .LANES(2), .PW(PW2)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(q_ctl[i]), .dvs_in(q_dvs[i]), .rem_in(q_rem[i]), .quo_in(q_quo[i]),
      .pl_in(q_pl[i]),
      .ctl_out(q_ctl[i+1]), .dvs_out(q_dvs[i+1]), .rem_out(q_rem[i+1]),
      .quo_out(q_quo[i+1]), .pl_out(q_pl[i+1])
    );
  end

  // Vector component roots.
  hse_pkg::ctl_t         v_ctl  [0:VN];
  logic [1:0][2*VN-1:0]  v_x    [0:VN];
  logic [1:0][VN:0]      v_rem  [0:VN];
  logic [1:0][VN-1:0]    v_root [0:VN];
  logic [PW2-1:0]        v_pl   [0:VN];

  assign v_ctl[0]  = q_ctl[DN];
  assign v_x[0]    = {{1'b0, q_quo[DN][1]}, {1'b0, q_quo[DN][0]}};
  assign v_rem[0]  = '0;
  assign v_root[0] = '0;
  assign v_pl[0]   = q_pl[DN];

  for (genvar i = 0; i < VN; i++) begin : g_vec
    hse_sqrt_cell #(.N(VN), .LANES(2), .PW(PW2)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(v_ctl[i]), .x_in(v_x[i]), .rem_in(v_rem[i]), .root_in(v_root[i]),
      .pl_in(v_pl[i]),
      .ctl_out(v_ctl[i+1]), .x_out(v_x[i+1]), .rem_out(v_rem[i+1]),
      .root_out(v_root[i+1]), .pl_out(v_pl[i+1])
    );
  end

  // Signs, zero vector, ordering and output register.
  logic             f_swap, f_neg, f_zero;
  logic [EW-1:0]    f_lam1, f_lam2;
  logic [OW-1:0]    nx, ny, qx, qy;

  assign {f_swap, f_neg, f_zero, f_lam1, f_lam2} = v_pl[VN];
  assign qx = {1'b0, v_root[VN][0]};
  assign qy = {1'b0, v_root[VN][1]};
  assign nx = f_zero ? '0 : (f_neg ? OW'(0) - qx : qx);
  assign ny = f_zero ? '0 : qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      last_out <= 1'b0;
    end else begin
      done     <= v_ctl[VN].valid;
      last_out <= v_ctl[VN].last;
    end
    if (f_swap) begin
      small_eig_x2 <= f_lam2;
      large_eig_x2 <= f_lam1;
      small_vec_x  <= nx;
      small_vec_y  <= ny;
      large_vec_x  <= OW'(0) - ny;
      large_vec_y  <= nx;
    end else begin
      small_eig_x2 <= f_lam1;
      large_eig_x2 <= f_lam2;
      small_vec_x  <= OW'(0) - ny;
      small_vec_y  <= nx;
      large_vec_x  <= nx;
      large_vec_y  <= ny;
    end
  end

endmodule

// ----- tb/tb_hessian_eigen_2x2.sv -----
// Self-checking testbench for the 2x2 Hessian eigen decomposition block.
`timescale 1ns / 100ps

module tb_hessian_eigen_2x2;

  localparam int IN_WIDTH = 16;
  localparam int VEC_FRAC = 14;
  localparam int LATENCY = IN_WIDTH + 3 * VEC_FRAC + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 830;

  typedef struct {
    logic signed [IN_WIDTH+2:0] small_eig_x2;
    logic signed [IN_WIDTH+2:0] large_eig_x2;
    logic signed [VEC_FRAC+1:0] small_vec_x;
    logic signed [VEC_FRAC+1:0] small_vec_y;
    logic signed [VEC_FRAC+1:0] large_vec_x;
    logic signed [VEC_FRAC+1:0] large_vec_y;
    logic                       last_out;
  } eigen_result_t;

  function automatic longint unsigned isqrt_floor(input bit [127:0] x);
    bit [127:0] r;
    bit [127:0] c;
    r = '0;
    for (int b = 45; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return longint'(r);
  endfunction

  function automatic longint unit_component(input longint n, input longint s);
    bit [127:0] sq;
    bit [127:0] quo;
    longint q;
    sq = 128'(n < 0 ? -n : n);
    sq = sq * sq;
    quo = (sq << (2 * VEC_FRAC)) / 128'(s);
    q = isqrt_floor(quo);
    return n < 0 ? -q : q;
  endfunction

  class eigen_scoreboard;
    eigen_result_t pending[$];
    int errors = 0;
    int items_in = 0;
    int results_seen = 0;
    int ties = 0;
    int zero_vecs = 0;

    function void note_pixel(logic signed [IN_WIDTH-1:0] hxx, logic signed [IN_WIDTH-1:0] hxy,
                             logic signed [IN_WIDTH-1:0] hyy, logic lastp);
      longint xx, xy, yy, d, root, vx, vy, s, nx, ny, lam1, lam2, a1, a2;
      eigen_result_t e;
      xx = hxx;
      xy = hxy;
      yy = hyy;
      d = xx - yy;
      root = isqrt_floor(128'(d * d + 4 * xy * xy));
      vx = 2 * xy;
      vy = yy - xx + root;
      s = vx * vx + vy * vy;
      nx = 0;
      ny = 0;
      if (s != 0) begin
        nx = unit_component(vx, s);
        ny = unit_component(vy, s);
      end else begin
        zero_vecs++;
      end
      lam1 = xx + yy - root;
      lam2 = xx + yy + root;
      a1 = lam1 < 0 ? -lam1 : lam1;
      a2 = lam2 < 0 ? -lam2 : lam2;
      if (a1 == a2) ties++;
      if (a1 > a2) begin
        e.small_eig_x2 = lam2;
        e.large_eig_x2 = lam1;
        e.small_vec_x = nx;
        e.small_vec_y = ny;
        e.large_vec_x = -ny;
        e.large_vec_y = nx;
      end else begin
        e.small_eig_x2 = lam1;
        e.large_eig_x2 = lam2;
        e.small_vec_x = -ny;
        e.small_vec_y = nx;
        e.large_vec_x = nx;
        e.large_vec_y = ny;
      end
      e.last_out = lastp;
      pending.push_back(e);
      items_in++;
    endfunction

    function void check_result(eigen_result_t got);
      eigen_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $error("Result arrived with no item outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.small_eig_x2 !== e.small_eig_x2) begin
        $error("small_eig_x2: expected %0d, got %0d", e.small_eig_x2, got.small_eig_x2);
        errors++;
      end
      if (got.large_eig_x2 !== e.large_eig_x2) begin
        $error("large_eig_x2: expected %0d, got %0d", e.large_eig_x2, got.large_eig_x2);
        errors++;
      end
      if (got.small_vec_x !== e.small_vec_x) begin
        $error("small_vec_x: expected %0d, got %0d", e.small_vec_x, got.small_vec_x);
        errors++;
      end
      if (got.small_vec_y !== e.small_vec_y) begin
        $error("small_vec_y: expected %0d, got %0d", e.small_vec_y, got.small_vec_y);
        errors++;
      end
      if (got.large_vec_x !== e.large_vec_x) begin
        $error("large_vec_x: expected %0d, got %0d", e.large_vec_x, got.large_vec_x);
        errors++;
      end
      if (got.large_vec_y !== e.large_vec_y) begin
        $error("large_vec_y: expected %0d, got %0d", e.large_vec_y, got.large_vec_y);
        errors++;
      end
      if (got.last_out !== e.last_out) begin
        $error("last_out: expected %0b, got %0b", e.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [IN_WIDTH-1:0] hess_xx;
  logic signed [IN_WIDTH-1:0] hess_xy;
  logic signed [IN_WIDTH-1:0] hess_yy;
  logic last_pixel;
  logic done;
  logic signed [IN_WIDTH+2:0] small_eig_x2;
  logic signed [IN_WIDTH+2:0] large_eig_x2;
  logic signed [VEC_FRAC+1:0] small_vec_x;
  logic signed [VEC_FRAC+1:0] small_vec_y;
  logic signed [VEC_FRAC+1:0] large_vec_x;
  logic signed [VEC_FRAC+1:0] large_vec_y;
  logic last_out;

  eigen_scoreboard board = new();
  int cycles = 0;
  bit no_gaps = 0;

  hessian_eigen_2x2 #(.IN_WIDTH(IN_WIDTH), .VEC_FRAC(VEC_FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .hess_xx(hess_xx), .hess_xy(hess_xy), .hess_yy(hess_yy), .last_pixel(last_pixel),
    .done(done), .small_eig_x2(small_eig_x2), .large_eig_x2(large_eig_x2),
    .small_vec_x(small_vec_x), .small_vec_y(small_vec_y),
    .large_vec_x(large_vec_x), .large_vec_y(large_vec_y), .last_out(last_out)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    eigen_result_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (!rst && start && !busy) board.note_pixel(hess_xx, hess_xy, hess_yy, last_pixel);
    if (!rst && done) begin
      got.small_eig_x2 = small_eig_x2;
      got.large_eig_x2 = large_eig_x2;
      got.small_vec_x = small_vec_x;
      got.small_vec_y = small_vec_y;
      got.large_vec_x = large_vec_x;
      got.large_vec_y = large_vec_y;
      got.last_out = last_out;
      board.check_result(got);
    end
  end

  task automatic send_pixel(input int xx, input int xy, input int yy, input bit lastp);
    int gap;
    start <= 1'b1;
    hess_xx <= xx;
    hess_xy <= xy;
    hess_yy <= yy;
    last_pixel <= lastp;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      hess_xx <= $urandom;
      hess_xy <= $urandom;
      hess_yy <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 40)) - 20;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  initial begin
    int xx;
    int yy;
    rst = 1'b1;
    start = 1'b0;
    hess_xx = '0;
    hess_xy = '0;
    hess_yy = '0;
    last_pixel = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    no_gaps = 1;
    send_pixel(0, 0, 0, 0);
    send_pixel(32767, 32767, 32767, 0);
    send_pixel(-32768, -32768, -32768, 1);
    send_pixel(32767, -32768, -32768, 0);
    send_pixel(-32768, 32767, 32767, 0);
    send_pixel(-32768, -32768, 32767, 0);
    send_pixel(32767, 32767, -32768, 1);
    send_pixel(32767, 0, -32768, 0);
    send_pixel(-32768, 0, 32767, 0);
    send_pixel(100, 0, 7, 0);
    send_pixel(7, 0, 100, 0);
    send_pixel(5, 0, -5, 0);
    send_pixel(-9, 0, 9, 1);
    send_pixel(40, 0, 40, 0);
    send_pixel(0, 1, 0, 0);
    send_pixel(0, -1, 0, 0);
    send_pixel(3, 4, -3, 0);
    send_pixel(-1, 1, 1, 0);
    send_pixel(1, -32768, 0, 0);
    send_pixel(-21846, 12345, 21845, 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      xx = pick_value();
      yy = $urandom_range(0, 7) == 0 ? xx : pick_value();
      if ($urandom_range(0, 9) == 0) yy = -xx;
      send_pixel(xx, $urandom_range(0, 7) == 0 ? 0 : pick_value(), yy,
                 $urandom_range(0, 7) == 0);
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Covered %0d pixels and %0d results, with %0d magnitude ties and %0d zero vectors.",
             board.items_in, board.results_seen, board.ties, board.zero_vecs);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
